// File: design/ssa_pkg.sv
// Shared types and constants for the sparse-set slot allocator.
package ssa_pkg;

  localparam int SLOTS   = 1024;
  localparam int SLOT_W  = 10;
  localparam int COUNT_W = SLOT_W + 1;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_MARK  = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_SAME = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [SLOT_W-1:0] slot_index;
  } in_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  granted_slot;
    status_t            status;
    logic [COUNT_W-1:0] allocated_total;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic init_step;
    logic load;
    logic read;
    logic wr_a;
    logic wr_b;
    logic respond;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic init_done;
    logic fail;
    logic is_swap;
  } stat_t;

endpackage

// File: design/ssa_ctrl.sv
// Controller state machine: init sweep, read, check, two swap writes.
module ssa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  ssa_pkg::stat_t stat,
  output ssa_pkg::ctrl_t ctrl,
  output logic          busy
);

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_CHECK = 6'b001000,
    S_WR1   = 6'b010000,
    S_WR2   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    case (state_r)
      S_INIT: begin
        ctrl.init_step = 1'b1;
        if (stat.init_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          ctrl.load = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        ctrl.read = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.fail || !stat.is_swap) begin
          ctrl.respond = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_WR1;
        end
      end
      S_WR1: begin
        ctrl.wr_a = 1'b1;
        state_nxt = S_WR2;
      end
      S_WR2: begin
        ctrl.wr_b    = 1'b1;
        ctrl.respond = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// File: design/ssa_datapath.sv
// Datapath: permutation memories, allocated count and result register.
module ssa_datapath (
  input  logic           clk,
  input  logic           rst_n,
  input  ssa_pkg::in_t   in_data,
  input  ssa_pkg::ctrl_t ctrl,
  output ssa_pkg::stat_t stat,
  output logic           out_valid,
  output ssa_pkg::out_t  out_data
);

  logic [ssa_pkg::SLOT_W-1:0]  sap_mem [ssa_pkg::SLOTS];
  logic [ssa_pkg::SLOT_W-1:0]  pos_mem [ssa_pkg::SLOTS];

  logic [ssa_pkg::SLOT_W-1:0]  icnt_r;
  logic [ssa_pkg::COUNT_W-1:0] count_r, count_nxt;
  ssa_pkg::cmd_t               cmd_r;
  logic [ssa_pkg::SLOT_W-1:0]  slot_r;
  logic [ssa_pkg::SLOT_W-1:0]  sap_rd_r;   // displaced slot / granted slot
  logic [ssa_pkg::SLOT_W-1:0]  pos_rd_r;   // old position of slot_r
  logic                        out_valid_r;
  ssa_pkg::out_t               out_r, out_nxt;

  logic [ssa_pkg::COUNT_W-1:0] tgt_full;
  logic [ssa_pkg::SLOT_W-1:0]  tgt;
  logic                        oor, pos_below;
  logic                        sap_we, pos_we;
  logic [ssa_pkg::SLOT_W-1:0]  sap_addr, pos_addr, sap_wdata, pos_wdata;

  // mark targets the boundary, free the last allocated position
  assign tgt_full  = (cmd_r == ssa_pkg::CMD_FREE) ? count_r - 1'b1 : count_r;
  assign tgt       = tgt_full[ssa_pkg::SLOT_W-1:0];
  assign oor       = {1'b0, slot_r} >= ssa_pkg::COUNT_W'(ssa_pkg::SLOTS);
  assign pos_below = {1'b0, pos_rd_r} < count_r;

  always_comb begin
    sap_we    = ctrl.init_step | ctrl.wr_a | ctrl.wr_b;
    pos_we    = sap_we;
    sap_addr  = tgt;
    sap_wdata = slot_r;
    pos_addr  = slot_r;
    pos_wdata = tgt;
    if (ctrl.init_step) begin
      sap_addr  = icnt_r;
      sap_wdata = icnt_r;
      pos_addr  = icnt_r;
      pos_wdata = icnt_r;
    end else if (ctrl.wr_b) begin
      sap_addr  = pos_rd_r;
      sap_wdata = sap_rd_r;
      pos_addr  = sap_rd_r;
      pos_wdata = pos_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (sap_we) sap_mem[sap_addr] <= sap_wdata;
    if (ctrl.read) sap_rd_r <= sap_mem[sap_addr];
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_addr] <= pos_wdata;
    if (ctrl.read) pos_rd_r <= pos_mem[pos_addr];
  end

  always_comb begin
    stat.init_done = (icnt_r == ssa_pkg::SLOT_W'(ssa_pkg::SLOTS - 1));
    stat.is_swap   = cmd_r inside {ssa_pkg::CMD_MARK, ssa_pkg::CMD_FREE};
    case (cmd_r)
      ssa_pkg::CMD_ALLOC: stat.fail = (count_r == ssa_pkg::COUNT_W'(ssa_pkg::SLOTS));
      ssa_pkg::CMD_MARK:  stat.fail = oor | pos_below;
      ssa_pkg::CMD_FREE:  stat.fail = oor | ~pos_below;
      default:            stat.fail = 1'b0;
    endcase
  end

  always_comb begin
    count_nxt           = count_r;
    out_nxt.granted_slot = '0;
    out_nxt.status      = ssa_pkg::ST_OK;
    case (cmd_r)
      ssa_pkg::CMD_ALLOC: begin
        if (stat.fail) begin
          out_nxt.status = ssa_pkg::ST_FULL;
        end else begin
          out_nxt.granted_slot = sap_rd_r;
          count_nxt            = count_r + 1'b1;
        end
      end
      ssa_pkg::CMD_MARK: begin
        if (stat.fail) out_nxt.status = ssa_pkg::ST_SAME;
        else count_nxt = count_r + 1'b1;
      end
      ssa_pkg::CMD_FREE: begin
        if (stat.fail) out_nxt.status = ssa_pkg::ST_SAME;
        else count_nxt = count_r - 1'b1;
      end
      default: begin
        count_nxt = '0;
      end
    endcase
    out_nxt.allocated_total = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      icnt_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl.respond;
      if (ctrl.init_step) icnt_r <= icnt_r + 1'b1;
      if (ctrl.respond) count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r  <= in_data.cmd;
      slot_r <= in_data.slot_index;
    end
    if (ctrl.respond) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: design/sparse_set_slot_allocator_top.sv
// Sparse-set slot allocator top level.
// Sequence: accept in idle, then read and check; allocate, clear and a rejected mark/free
//   respond from check, while a mark or free that swaps passes the write states S_WR1, S_WR2.
// A new transaction is accepted only in idle, never while one is in flight; the swap writes
//   go to the single-port permutation memories.
// Reset: synchronous; an init sweep writes identity into every entry of both
//   memories while busy is high. Results are strobed for one cycle; no stall.
module sparse_set_slot_allocator_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  ssa_pkg::in_t  in_data,
  output logic          busy,
  output logic          out_valid,
  output ssa_pkg::out_t out_data
);

  ssa_pkg::ctrl_t ctrl;
  ssa_pkg::stat_t stat;

  ssa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  ssa_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctrl      (ctrl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ssa_pkg::ST_FULL) |->
      (out_data.allocated_total == ssa_pkg::COUNT_W'(ssa_pkg::SLOTS) &&
       out_data.granted_slot == '0))
    else $error("full status with count below capacity or nonzero grant");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.allocated_total <= ssa_pkg::COUNT_W'(ssa_pkg::SLOTS))
    else $error("allocated count exceeds capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("block idle right after accepting a transaction");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result strobes");
`endif

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the slot allocator: queued command stimulus, predicted results.
module tb_top;

  localparam int IDLE_LIMIT   = 5000;  // covers the init sweep several times over
  localparam int RANDOM_ITEMS = 530;

  typedef struct {
    ssa_pkg::in_t req;
    int           gap;
  } pending_t;

  logic          clk     = 1'b0;
  logic          rst_n   = 1'b0;
  logic          start   = 1'b0;
  ssa_pkg::in_t  in_data = '0;
  logic          busy;
  logic          out_valid;
  ssa_pkg::out_t out_data;

  sparse_set_slot_allocator_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_data  (in_data),
    .busy     (busy),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // predicted allocator state
  logic [ssa_pkg::SLOT_W-1:0]  slot_at_pos [ssa_pkg::SLOTS];
  logic [ssa_pkg::SLOT_W-1:0]  pos_of_slot [ssa_pkg::SLOTS];
  logic [ssa_pkg::COUNT_W-1:0] alloc_count;

  pending_t      pending_q[$];
  ssa_pkg::out_t expected_results[$];

  int gap_left    = 0;
  int idle_cycles = 0;
  int failures    = 0;
  int accepted    = 0;
  int checked     = 0;
  int full_seen   = 0;
  int same_seen   = 0;
  bit no_idle     = 1'b0;
  int window_base = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Put slot s at position target; the slot that sat there takes s's old position.
  function automatic void place_slot(logic [ssa_pkg::SLOT_W-1:0] s,
                                     logic [ssa_pkg::SLOT_W-1:0] target);
    logic [ssa_pkg::SLOT_W-1:0] displaced;
    logic [ssa_pkg::SLOT_W-1:0] old_pos;
    displaced = slot_at_pos[target];
    old_pos   = pos_of_slot[s];
    slot_at_pos[target]    = s;
    slot_at_pos[old_pos]   = displaced;
    pos_of_slot[displaced] = old_pos;
    pos_of_slot[s]         = target;
  endfunction

  function automatic ssa_pkg::out_t predict_result(ssa_pkg::in_t req);
    ssa_pkg::out_t res;
    res        = '0;
    res.status = ssa_pkg::ST_OK;
    case (req.cmd)
      ssa_pkg::CMD_ALLOC: begin
        if (alloc_count >= ssa_pkg::SLOTS) begin
          res.status = ssa_pkg::ST_FULL;
        end else begin
          res.granted_slot = slot_at_pos[alloc_count[ssa_pkg::SLOT_W-1:0]];
          alloc_count++;
        end
      end
      ssa_pkg::CMD_MARK: begin
        if (int'(req.slot_index) >= ssa_pkg::SLOTS ||
            pos_of_slot[req.slot_index] < alloc_count) begin
          res.status = ssa_pkg::ST_SAME;
        end else begin
          place_slot(req.slot_index, alloc_count[ssa_pkg::SLOT_W-1:0]);
          alloc_count++;
        end
      end
      ssa_pkg::CMD_FREE: begin
        if (int'(req.slot_index) >= ssa_pkg::SLOTS ||
            pos_of_slot[req.slot_index] >= alloc_count) begin
          res.status = ssa_pkg::ST_SAME;
        end else begin
          alloc_count--;
          place_slot(req.slot_index, alloc_count[ssa_pkg::SLOT_W-1:0]);
        end
      end
      default: begin
        alloc_count = '0;
      end
    endcase
    res.allocated_total = alloc_count;
    return res;
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic void queue_cmd(ssa_pkg::cmd_t cmd, int slot);
    pending_t p;
    p.req.cmd        = cmd;
    p.req.slot_index = slot[ssa_pkg::SLOT_W-1:0];
    p.gap            = draw_gap();
    pending_q.push_back(p);
  endfunction

  // Mostly a narrow window so marks and frees hit allocated and free slots alike.
  function automatic int pick_slot();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return (window_base + $urandom_range(0, 15)) % ssa_pkg::SLOTS;
    if (r < 75) return 0;
    if (r < 80) return ssa_pkg::SLOTS - 1;
    return $urandom_range(0, ssa_pkg::SLOTS - 1);
  endfunction

  // Driver: one transaction is accepted on each edge where start is high and busy low.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      expected_results.push_back(predict_result(in_data));
      accepted++;
      if (pending_q.size() > 0 && pending_q[0].gap == 0) begin
        in_data <= pending_q[0].req;
        void'(pending_q.pop_front());
      end else begin
        start <= 1'b0;
        if (pending_q.size() > 0) gap_left <= pending_q[0].gap - 1;
      end
    end else if (!start && pending_q.size() > 0) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else begin
        start   <= 1'b1;
        in_data <= pending_q[0].req;
        void'(pending_q.pop_front());
      end
    end
  end

  // Monitor: results are strobed for one cycle and cannot be held off.
  always @(posedge clk) begin : result_check
    ssa_pkg::out_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: granted_slot %0d status %0d allocated_total %0d",
               out_data.granted_slot, out_data.status, out_data.allocated_total);
        failures++;
      end else begin
        want = expected_results.pop_front();
        checked++;
        if (out_data.granted_slot !== want.granted_slot) begin
          $error("granted_slot: expected %0d, got %0d", want.granted_slot,
                 out_data.granted_slot);
          failures++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          failures++;
        end
        if (out_data.allocated_total !== want.allocated_total) begin
          $error("allocated_total: expected %0d, got %0d", want.allocated_total,
                 out_data.allocated_total);
          failures++;
        end
        if (want.status == ssa_pkg::ST_FULL) full_seen++;
        if (want.status == ssa_pkg::ST_SAME) same_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("sparse_set_slot_allocator_top verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int r;
    for (int i = 0; i < ssa_pkg::SLOTS; i++) begin
      slot_at_pos[i] = i[ssa_pkg::SLOT_W-1:0];
      pos_of_slot[i] = i[ssa_pkg::SLOT_W-1:0];
    end
    alloc_count = '0;

    // directed: field extremes, repeats, free while empty, mark after clear
    queue_cmd(ssa_pkg::CMD_ALLOC, ssa_pkg::SLOTS - 1);
    queue_cmd(ssa_pkg::CMD_ALLOC, 0);
    queue_cmd(ssa_pkg::CMD_MARK, ssa_pkg::SLOTS - 1);
    queue_cmd(ssa_pkg::CMD_MARK, ssa_pkg::SLOTS - 1);
    queue_cmd(ssa_pkg::CMD_MARK, 0);
    queue_cmd(ssa_pkg::CMD_FREE, 0);
    queue_cmd(ssa_pkg::CMD_FREE, 0);
    queue_cmd(ssa_pkg::CMD_FREE, ssa_pkg::SLOTS - 1);
    queue_cmd(ssa_pkg::CMD_FREE, 1);
    queue_cmd(ssa_pkg::CMD_FREE, 512);
    queue_cmd(ssa_pkg::CMD_MARK, 512);
    queue_cmd(ssa_pkg::CMD_MARK, 341);
    queue_cmd(ssa_pkg::CMD_MARK, 682);
    queue_cmd(ssa_pkg::CMD_CLEAR, 682);
    queue_cmd(ssa_pkg::CMD_CLEAR, 0);
    queue_cmd(ssa_pkg::CMD_MARK, 341);
    queue_cmd(ssa_pkg::CMD_ALLOC, 341);
    queue_cmd(ssa_pkg::CMD_FREE, 341);
    queue_cmd(ssa_pkg::CMD_CLEAR, ssa_pkg::SLOTS - 1);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 60 == 0) begin
        no_idle     = ($urandom_range(0, 2) == 0);
        window_base = $urandom_range(0, ssa_pkg::SLOTS - 1);
      end
      r = $urandom_range(0, 99);
      if (r < 30) queue_cmd(ssa_pkg::CMD_ALLOC, $urandom_range(0, ssa_pkg::SLOTS - 1));
      else if (r < 62) queue_cmd(ssa_pkg::CMD_MARK, pick_slot());
      else if (r < 96) queue_cmd(ssa_pkg::CMD_FREE, pick_slot());
      else queue_cmd(ssa_pkg::CMD_CLEAR, $urandom_range(0, ssa_pkg::SLOTS - 1));
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() > 0 || start || expected_results.size() > 0) @(negedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d transactions, %0d results checked: directed edge cases, then a",
             accepted, checked);
    $display("random command mix with idle and back-to-back stretches; %0d store full,",
             full_seen);
    $display("%0d already in requested state, %0d mismatches.", same_seen, failures);
    if (failures == 0) begin
      $display("sparse_set_slot_allocator_top verification clean");
    end else begin
      $display("sparse_set_slot_allocator_top verification failed");
    end
    $finish;
  end

endmodule
